// ===== sv/htm_pkg.sv =====
// ----------------------------------------------------------------------------
// htm_pkg: shared types and constants of the HDR tone-mapping pipeline
// Widths of the fixed-point path and the beats passed between stages.
// ----------------------------------------------------------------------------
package htm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 10;
  localparam int X_W       = INT_BITS + FRAC_BITS;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 16;
  localparam int PROD_W    = X_W + GAIN_W;
  localparam int P_W       = X_W + GAIN_W - GAIN_FRAC;
  localparam int NUM_W     = P_W + 10;
  localparam int DEN_W     = P_W + 2;
  localparam int SIG_W     = 24 + FRAC_BITS;
  localparam int N_CH      = 3;
  localparam int DIV_ST    = 4;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(484249);
  localparam logic [7:0]        EXP_SAT    = 8'd137;
  localparam logic [7:0]        EXP_BIAS_S = 8'd150;
  localparam logic [7:0]        EXP_SPEC   = 8'hFF;
  localparam logic [7:0]        FULL_8     = 8'hFF;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic           inf;
  } dchan_t;

  typedef struct packed {
    dchan_t [N_CH-1:0] ch;
    logic              last;
  } dec_t;

  typedef struct packed {
    logic [P_W-1:0] p;
    logic           inf;
  } pchan_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [7:0]       q;
    logic             inf;
  } qchan_t;

  typedef struct packed {
    qchan_t [N_CH-1:0] ch;
    logic              last;
  } div_t;

endpackage

// ===== sv/htm_if.sv =====
// ----------------------------------------------------------------------------
// htm_if: stream channels of the tone-mapping block
// Pixel input, pixel output and the exposure gain write channel.
// ----------------------------------------------------------------------------
interface htm_pix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] red_in;
  logic [31:0] green_in;
  logic [31:0] blue_in;
  logic        last_pixel_in;
  modport source (output valid, red_in, green_in, blue_in, last_pixel_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, last_pixel_in, output ready);
endinterface

interface htm_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       last_pixel_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_pixel_out,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_pixel_out,
                  output ready);
endinterface

interface htm_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/htm_decode.sv =====
// ----------------------------------------------------------------------------
// htm_decode: float32 to unsigned fixed-point decode stage
// Turns each channel into Q10.FRAC_BITS with saturation and flags +Inf.
// ----------------------------------------------------------------------------
module htm_decode (
  input  logic                clk,
  input  logic                rst,
  htm_pix_in_if.sink          pix_in,
  input  logic                dn_ready,
  output logic                valid,
  output htm_pkg::dec_t       data
);

  logic          en;
  htm_pkg::dec_t data_next;
  logic [31:0]   bits [htm_pkg::N_CH];

  assign en           = !valid || dn_ready;
  assign pix_in.ready = en;
  assign bits[0]      = pix_in.red_in;
  assign bits[1]      = pix_in.green_in;
  assign bits[2]      = pix_in.blue_in;

  // Decode each channel: sign, zero, NaN give 0; large values saturate
  always_comb begin
    data_next      = '0;
    data_next.last = pix_in.last_pixel_in;
    for (int c = 0; c < htm_pkg::N_CH; c++) begin
      logic [7:0]               expo;
      logic [22:0]              mant;
      logic                     sgn;
      logic [htm_pkg::SIG_W-1:0] wide;
      logic [7:0]               rs;
      expo = bits[c][30:23];
      mant = bits[c][22:0];
      sgn  = bits[c][31];
      wide = htm_pkg::SIG_W'({1'b1, mant}) << htm_pkg::FRAC_BITS;
      rs   = htm_pkg::EXP_BIAS_S - expo;
      data_next.ch[c].inf = (expo == htm_pkg::EXP_SPEC) && (mant == '0) && !sgn;
      if (sgn || expo == '0 || expo == htm_pkg::EXP_SPEC) begin
        data_next.ch[c].x = '0;
      end else if (expo >= htm_pkg::EXP_SAT) begin
        data_next.ch[c].x = '1;
      end else begin
        data_next.ch[c].x = htm_pkg::X_W'(wide >> rs);
      end
    end
  end

  // Advance the stage when the next one can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

// ===== sv/htm_scale.sv =====
// ----------------------------------------------------------------------------
// htm_scale: exposure multiply and Reinhard operand stages
// Stage one forms p = x*gain >> 16, stage two the dividend and divisor.
// ----------------------------------------------------------------------------
module htm_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [htm_pkg::GAIN_W-1:0]    gain,
  input  logic                          up_valid,
  input  htm_pkg::dec_t                 up_data,
  output logic                          up_ready,
  input  logic                          dn_ready,
  output logic                          valid,
  output htm_pkg::div_t                 data
);

  logic                              en_p, en_d;
  logic                              valid_p;
  htm_pkg::pchan_t [htm_pkg::N_CH-1:0] p_ch;
  logic                              p_last;
  htm_pkg::pchan_t [htm_pkg::N_CH-1:0] p_ch_next;
  htm_pkg::div_t                     data_next;

  assign en_d     = !valid || dn_ready;
  assign en_p     = !valid_p || en_d;
  assign up_ready = en_p;

  // Multiply by the exposure gain and drop its fraction bits
  always_comb begin
    for (int c = 0; c < htm_pkg::N_CH; c++) begin
      logic [htm_pkg::PROD_W-1:0] prod;
      prod = htm_pkg::PROD_W'(up_data.ch[c].x) * htm_pkg::PROD_W'(gain);
      p_ch_next[c].p   = prod[htm_pkg::PROD_W-1:htm_pkg::GAIN_FRAC];
      p_ch_next[c].inf = up_data.ch[c].inf;
    end
  end

  // Form dividend 511p + one and divisor 2(one + p)
  always_comb begin
    data_next      = '0;
    data_next.last = p_last;
    for (int c = 0; c < htm_pkg::N_CH; c++) begin
      data_next.ch[c].rem = (htm_pkg::NUM_W'(p_ch[c].p) << 9) - htm_pkg::NUM_W'(p_ch[c].p)
                          + (htm_pkg::NUM_W'(1) << htm_pkg::FRAC_BITS);
      data_next.ch[c].den = (htm_pkg::DEN_W'(p_ch[c].p) << 1)
                          + (htm_pkg::DEN_W'(1) << (htm_pkg::FRAC_BITS + 1));
      data_next.ch[c].q   = '0;
      data_next.ch[c].inf = p_ch[c].inf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p <= 1'b0;
      valid   <= 1'b0;
    end else begin
      if (en_p) begin
        valid_p <= up_valid;
      end
      if (en_d) begin
        valid <= valid_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      p_ch   <= p_ch_next;
      p_last <= up_data.last;
    end
    if (en_d) begin
      data <= data_next;
    end
  end

endmodule

// ===== sv/htm_div.sv =====
// ----------------------------------------------------------------------------
// htm_div: pipelined restoring divider
// Four stages, two quotient bits each, give the 8-bit rounded channel.
// ----------------------------------------------------------------------------
module htm_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  htm_pkg::div_t up_data,
  output logic          up_ready,
  input  logic          dn_ready,
  output logic          valid,
  output htm_pkg::div_t data
);

  htm_pkg::div_t st      [htm_pkg::DIV_ST];
  htm_pkg::div_t src     [htm_pkg::DIV_ST];
  htm_pkg::div_t st_next [htm_pkg::DIV_ST];
  logic [htm_pkg::DIV_ST-1:0] v;
  logic [htm_pkg::DIV_ST-1:0] src_v;
  logic [htm_pkg::DIV_ST:0]   en;

  assign en[htm_pkg::DIV_ST] = dn_ready;
  assign up_ready            = en[0];
  assign valid               = v[htm_pkg::DIV_ST-1];
  assign data                = st[htm_pkg::DIV_ST-1];

  for (genvar j = 0; j < htm_pkg::DIV_ST; j++) begin : g_st
    if (j == 0) begin : g_first
      assign src[j]   = up_data;
      assign src_v[j] = up_valid;
    end else begin : g_rest
      assign src[j]   = st[j-1];
      assign src_v[j] = v[j-1];
    end

    assign en[j] = !v[j] || en[j+1];

    // Take two quotient bits: subtract the shifted divisor where it fits
    always_comb begin
      st_next[j] = src[j];
      for (int c = 0; c < htm_pkg::N_CH; c++) begin
        for (int b = 0; b < 2; b++) begin
          logic [htm_pkg::NUM_W-1:0] trial;
          int                        k;
          k     = 7 - 2 * j - b;
          trial = htm_pkg::NUM_W'(st_next[j].ch[c].den) << k;
          if (st_next[j].ch[c].rem >= trial) begin
            st_next[j].ch[c].rem  = st_next[j].ch[c].rem - trial;
            st_next[j].ch[c].q[k[2:0]] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= src_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st[j] <= st_next[j];
      end
    end
  end

endmodule

// ===== sv/hdr_tonemap_to_rgba8.sv =====
// Pipeline: decode, multiply, operand forming and four divider stages are
// registered between input beat and output beat.
// Throughput: one pixel per cycle; each stage holds under back-pressure and
// fills its bubbles while the output waits.
// Reset: synchronous rst clears all valid bits and sets the exposure gain
// to e squared (484249 in Q8.16).
// ----------------------------------------------------------------------------
// hdr_tonemap_to_rgba8: Reinhard tone mapping of float32 RGB to RGBA8
// Decode, exposure scale and pipelined division, one pixel per clock.
// ----------------------------------------------------------------------------
module hdr_tonemap_to_rgba8 (
  input  logic         clk,
  input  logic         rst,
  htm_cfg_if.sink      cfg,
  htm_pix_in_if.sink   pix_in,
  htm_pix_out_if.source pix_out
);

  logic [htm_pkg::GAIN_W-1:0] gain;
  logic                       dec_valid, dec_ready;
  htm_pkg::dec_t              dec_data;
  logic                       sc_valid, sc_ready;
  htm_pkg::div_t              sc_data;
  logic                       dv_valid;
  htm_pkg::div_t              dv_data;

  assign cfg.ready = 1'b1;

  // Hold the exposure gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= htm_pkg::GAIN_RESET;
    end else if (cfg.valid) begin
      gain <= cfg.data;
    end
  end

  htm_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .dn_ready (dec_ready),
    .valid    (dec_valid),
    .data     (dec_data)
  );

  htm_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .gain     (gain),
    .up_valid (dec_valid),
    .up_data  (dec_data),
    .up_ready (dec_ready),
    .dn_ready (sc_ready),
    .valid    (sc_valid),
    .data     (sc_data)
  );

  htm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sc_valid),
    .up_data  (sc_data),
    .up_ready (sc_ready),
    .dn_ready (pix_out.ready),
    .valid    (dv_valid),
    .data     (dv_data)
  );

  // Drive the output beat; +Inf forces full scale
  assign pix_out.valid          = dv_valid;
  assign pix_out.red_out        = dv_data.ch[0].inf ? htm_pkg::FULL_8 : dv_data.ch[0].q;
  assign pix_out.green_out      = dv_data.ch[1].inf ? htm_pkg::FULL_8 : dv_data.ch[1].q;
  assign pix_out.blue_out       = dv_data.ch[2].inf ? htm_pkg::FULL_8 : dv_data.ch[2].q;
  assign pix_out.alpha_out      = htm_pkg::FULL_8;
  assign pix_out.last_pixel_out = dv_data.last;

endmodule
